### design/brcc_pkg.sv
package brcc_pkg;

  // Configuration field widths
  localparam int WordLenW  = 5;
  localparam int RunLimW   = 5;
  localparam int BalLimW   = 4;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 5;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_WORD_LEN  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RUN_LIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BAL_LIMIT = 2'd2;

  // Reset values
  localparam logic [WordLenW-1:0] WORD_LEN_RST  = 5'd16;
  localparam logic [RunLimW-1:0]  RUN_LIMIT_RST = 5'd3;
  localparam logic [BalLimW-1:0]  BAL_LIMIT_RST = 4'd2;

  // Live configuration handed to the checker
  typedef struct packed {
    logic [WordLenW-1:0] word_len;
    logic [RunLimW-1:0]  run_limit;
    logic [BalLimW-1:0]  balance_limit;
  } cfg_t;

endpackage

### design/brcc_cfg_regs.sv
module brcc_cfg_regs
  import brcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data,
  output cfg_t                cfg
);

  cfg_t regs;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.word_len      <= WORD_LEN_RST;
      regs.run_limit     <= RUN_LIMIT_RST;
      regs.balance_limit <= BAL_LIMIT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_WORD_LEN:  regs.word_len      <= wr_data[WordLenW-1:0];
        REG_RUN_LIMIT: regs.run_limit     <= wr_data[RunLimW-1:0];
        REG_BAL_LIMIT: regs.balance_limit <= wr_data[BalLimW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

### design/brcc_eval.sv
module brcc_eval
  import brcc_pkg::*;
#(
  parameter int MAX_WIDTH = 16
) (
  input  cfg_t                 cfg,
  input  logic [MAX_WIDTH-1:0] word,
  output logic                 ok
);

  localparam int CW = $clog2(MAX_WIDTH + 1);   // count width
  localparam int DW = CW + 2;                  // signed disparity width
  localparam int KW = (DW > 6) ? DW : 6;       // compare width
  localparam int EW = MAX_WIDTH - 1;           // adjacent-pair flags

  logic [MAX_WIDTH-1:0] all_ones;
  logic [EW-1:0]        pair_ones;
  logic [EW-1:0]        ne;
  logic [EW-1:0]        win_mask;
  logic [EW-1:0]        tail_mask;
  logic [RunLimW-1:0]   rho_m1;
  logic [4:0]           lim2;
  logic                 len_ok;
  logic                 disp_ok;
  logic                 long_run;
  logic                 tail_bad;

  assign all_ones  = '1;
  assign pair_ones = '1;

  // Word length must be even and within the port
  assign len_ok = (cfg.word_len >= 5'd2) && (32'(cfg.word_len) <= MAX_WIDTH)
                  && !cfg.word_len[0];

  assign lim2 = {cfg.balance_limit, 1'b0};

  // Suffix disparity: one popcount per suffix length, all in parallel.
  // Odd lengths use a strict compare, i.e. bound 2*delta-1.
  always_comb begin
    logic [MAX_WIDTH-1:0] mask;
    logic [CW-1:0]        cnt;
    logic [DW-1:0]        dbl;
    logic signed [DW-1:0] diff;
    logic [DW-1:0]        mag;
    logic                 active;
    logic                 bad;
    disp_ok = 1'b1;
    for (int l = 1; l <= MAX_WIDTH; l++) begin
      mask   = all_ones >> (MAX_WIDTH - l);
      cnt    = CW'($countones(word & mask));
      dbl    = {1'b0, cnt, 1'b0};
      diff   = $signed(dbl) - $signed(DW'(l));
      mag    = diff[DW-1] ? DW'(-diff) : DW'(diff);
      active = (32'(l) <= 32'(cfg.word_len));
      if (l % 2 == 0) begin
        bad = KW'(mag) > KW'(lim2);
      end else begin
        bad = KW'(mag) >= KW'(lim2);
      end
      // full word must be exactly balanced
      if (32'(l) == 32'(cfg.word_len) && diff != '0) begin
        bad = 1'b1;
      end
      if (active && bad) begin
        disp_ok = 1'b0;
      end
    end
  end

  // Adjacent bits that differ
  always_comb begin
    for (int k = 0; k < EW; k++) begin
      ne[k] = word[k] ^ word[k+1];
    end
  end

  // Runs: rho+1 equal bits means rho equal pairs in a row
  assign rho_m1    = cfg.run_limit - 5'd1;
  assign win_mask  = ~(pair_ones << cfg.run_limit);
  assign tail_mask = ~(pair_ones << rho_m1);

  always_comb begin
    logic [EW-1:0] sel;
    long_run = 1'b0;
    for (int j = 0; j < EW; j++) begin
      sel = (ne >> j) & win_mask;
      if ((32'(j) + 32'(cfg.run_limit) + 1 <= 32'(cfg.word_len)) && (sel == '0)) begin
        long_run = 1'b1;
      end
    end
  end

  // Final run (ending at bit 0) must stay below the run limit
  assign tail_bad = (cfg.run_limit == '0) ||
                    ((32'(cfg.run_limit) <= 32'(cfg.word_len)) && ((ne & tail_mask) == '0));

  assign ok = len_ok && disp_ok && (cfg.run_limit != '0) && !long_run && !tail_bad;

endmodule

### design/balanced_rll_codeword_check.sv
// Balanced run-length-limited codeword checker. Each item on the input channel
// is one candidate word; exactly one result item comes back, accepted = 1 when
// word_len is even, 2..MAX_WIDTH, run_limit nonzero and the low word_len bits
// (bit word_len-1 read first) are balanced, keep every suffix disparity within
// 2*balance_limit (2*balance_limit-1 for odd suffix lengths), have no run longer
// than run_limit and end in a run shorter than run_limit. Throughput is one item
// per cycle while out_stall is low; an item lands in the input register when
// accepted, its result in the result register once that register is free, with
// the single evaluation stage between them. The configuration port is always
// ready; write registers only while no item is in flight.
module balanced_rll_codeword_check
  import brcc_pkg::*;
#(
  parameter int MAX_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  // candidate items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MAX_WIDTH-1:0] candidate,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 accepted
);

  cfg_t                 cfg;
  logic                 s1_valid;
  logic [MAX_WIDTH-1:0] s1_word;
  logic                 s2_valid;
  logic                 s2_ok;
  logic                 eval_ok;
  logic                 adv2;
  logic                 adv1;

  assign cfg_ready = 1'b1;

  brcc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  brcc_eval #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_eval (
    .cfg  (cfg),
    .word (s1_word),
    .ok   (eval_ok)
  );

  // Stage advance: a stage moves when the one after it is free
  assign adv2     = !s2_valid || !out_stall;
  assign adv1     = !s1_valid || adv2;
  assign in_stall = !adv1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_word <= candidate;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      s2_ok <= eval_ok;
    end
  end

  assign out_valid = s2_valid;
  assign accepted  = s2_ok;

endmodule
